### hdl/rhp_pkg.sv
// Shared types and constants for the RTP header parser.
`timescale 1ns / 1ps
`default_nettype none

package rhp_pkg;

	// Largest packet that is counted before the overflow flag is raised.
	localparam logic [15:0] MAX_PACKET_BYTES = 16'hFFFF;

	// Fixed RTP header size and first-byte field masks.
	localparam logic [15:0] FIXED_HDR_BYTES = 16'd12;
	localparam logic [7:0]  VERSION_MASK    = 8'hC0;
	localparam logic [7:0]  VERSION_2       = 8'h80;
	localparam int unsigned BIT_PADDING     = 5;
	localparam int unsigned BIT_EXTENSION   = 4;
	localparam logic [15:0] EXT_HDR_BYTES   = 16'd4;

	// Configuration register word indexes.
	localparam logic REG_STRIP_PADDING = 1'b0;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_SHORT_HDR     = 3'd1,
		ST_BAD_VER       = 3'd2,
		ST_SHORT_CSRC    = 3'd3,
		ST_SHORT_EXT_HDR = 3'd4,
		ST_SHORT_EXT     = 3'd5,
		ST_BAD_PAD       = 3'd6,
		ST_TOO_LONG      = 3'd7
	} status_t;

	// What the byte tracker knows about a packet once a byte has been taken.
	typedef struct packed {
		logic [15:0] len;
		logic [7:0]  hdr;
		logic [15:0] ext_words;
		logic        overflow;
		logic [7:0]  data;
	} pkt_snap_t;

	// One result item; packed so that status sits in the lowest bits.
	typedef struct packed {
		logic [7:0]  header_byte;
		logic [7:0]  padding_length;
		logic [15:0] payload_length;
		logic [15:0] payload_offset;
		status_t     status;
	} result_t;

endpackage

`default_nettype wire

### hdl/rhp_result.sv
// End-of-packet checks: status, payload offset and length, padding length.
`timescale 1ns / 1ps
`default_nettype none

module rhp_result import rhp_pkg::*; (
	input  wire pkt_snap_t snap,
	input  wire logic      strip_padding,
	output result_t        res
);

	logic [15:0] csrc_end;
	logic [18:0] ext_end;
	logic [18:0] hdr_end;
	logic [15:0] after_csrc;
	logic [15:0] plen_raw;
	logic        has_ext;
	logic        has_pad;

	assign has_ext    = snap.hdr[BIT_EXTENSION];
	assign has_pad    = snap.hdr[BIT_PADDING];
	assign csrc_end   = FIXED_HDR_BYTES + {10'd0, snap.hdr[3:0], 2'b00};
	assign after_csrc = snap.len - csrc_end;
	assign ext_end    = {3'd0, csrc_end} + {3'd0, EXT_HDR_BYTES} + {1'b0, snap.ext_words, 2'b00};
	assign hdr_end    = has_ext ? ext_end : {3'd0, csrc_end};
	assign plen_raw   = snap.len - hdr_end[15:0];

	always_comb begin
		res = '0;
		res.header_byte = snap.hdr;
		priority if (snap.overflow) begin
			res.status = ST_TOO_LONG;
		end else if (snap.len < FIXED_HDR_BYTES) begin
			res.status = ST_SHORT_HDR;
		end else if ((snap.hdr & VERSION_MASK) != VERSION_2) begin
			res.status = ST_BAD_VER;
		end else if (snap.len < csrc_end) begin
			res.status = ST_SHORT_CSRC;
		end else if (has_ext && (after_csrc < EXT_HDR_BYTES)) begin
			res.status = ST_SHORT_EXT_HDR;
		end else if ({3'd0, snap.len} < hdr_end) begin
			res.status = ST_SHORT_EXT;
		end else if (strip_padding && has_pad) begin
			if ((plen_raw == 16'd0) || (plen_raw < {8'd0, snap.data})) begin
				res.status = ST_BAD_PAD;
			end else begin
				res.status         = ST_OK;
				res.payload_offset = hdr_end[15:0];
				res.padding_length = snap.data;
				res.payload_length = plen_raw - {8'd0, snap.data};
			end
		end else begin
			res.status         = ST_OK;
			res.payload_offset = hdr_end[15:0];
			res.payload_length = plen_raw;
		end
	end

endmodule

`default_nettype wire

### hdl/rtp_header_parser.sv
// Top level of the RTP header parser: byte tracker, check stage and ports.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes an RTP packet one byte per transfer on the slave stream,
// with s_tlast on the final byte, and gives one result transfer per packet on
// the master stream. It takes one byte every clock cycle while s_tready is
// high. Each byte updates a small tracker (byte count, first header byte,
// previous byte, the big-endian extension length found at offsets
// 12 + 4*CC + 2 and + 3, and an overflow flag) and is copied with that
// snapshot into an input register. The final byte's snapshot passes from
// the input register through the header checks into the result register.
// The slave side keeps taking bytes while a result waits to be transferred;
// it stalls only when a second finished packet would meet a result register
// still full. Status codes: 0 ok, 1 header shorter than 12 bytes, 2 version
// not 2, 3 CSRC list cut short, 4 extension header cut short, 5 extension
// words cut short, 6 bad padding count, 7 packet longer than 65535 bytes.
// Offset, lengths and padding are zero unless the status is ok. The single
// register, strip_padding at address 0 (reset 1), is to be written only
// while the parser is idle.

module rtp_header_parser import rhp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave stream: tdata = data_byte[7:0]; tlast = last_byte
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic        s_tlast,
	// master stream: tdata = status[2:0], payload_offset[18:3],
	// payload_length[34:19], padding_length[42:35], header_byte[50:43], zero[55:51]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// Configuration register.
	logic strip_q;

	// Per-packet tracker state.
	logic [15:0] count_q;
	logic [7:0]  hdr_q;
	logic [15:0] ext_q;
	logic [7:0]  prev_q;
	logic        ovf_q;

	// Input register and result register.
	pkt_snap_t snap_s1;
	logic      last_s1;
	logic      valid_s1;
	result_t   res_q;
	logic      out_valid_q;

	logic        accept;
	logic        out_free;
	logic        s1_done;
	logic        s1_to_out;
	logic        cfg_write;
	logic [15:0] ext_pos;
	pkt_snap_t   snap_nx;
	logic [15:0] ext_nx;
	result_t     res_nx;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;
	assign prdata    = (paddr[2] == REG_STRIP_PADDING) ? {31'd0, strip_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_q <= 1'b1;
		end else if (cfg_write && (paddr[2] == REG_STRIP_PADDING)) begin
			strip_q <= pwdata[0];
		end
	end

	// Handshake. The result register frees when it is empty or being drained;
	// the input register moves on at once for a mid-packet byte, and for a
	// final byte only when the result register can take it.
	assign out_free  = !out_valid_q || m_tready;
	assign s1_done   = valid_s1 && (!last_s1 || out_free);
	assign s1_to_out = valid_s1 && last_s1 && out_free;
	assign s_tready  = !valid_s1 || s1_done;
	assign accept    = s_tvalid && s_tready;

	// Tracker update for the byte now offered. The extension length ends at
	// 12 + 4*CC + 3, which is never byte 0, so the stored header byte serves.
	assign ext_pos = 16'd15 + {10'd0, hdr_q[3:0], 2'b00};
	assign ext_nx  = ((count_q != 16'd0) && (count_q == ext_pos)) ? {prev_q, s_tdata} : ext_q;

	always_comb begin
		snap_nx.hdr       = (count_q == 16'd0) ? s_tdata : hdr_q;
		snap_nx.ext_words = ext_nx;
		snap_nx.overflow  = ovf_q || (count_q >= MAX_PACKET_BYTES);
		snap_nx.len       = (count_q >= MAX_PACKET_BYTES) ? count_q : count_q + 16'd1;
		snap_nx.data      = s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hdr_q   <= '0;
			ext_q   <= '0;
			prev_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				// Packet complete: the tracker starts afresh.
				count_q <= '0;
				hdr_q   <= '0;
				ext_q   <= '0;
				prev_q  <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= snap_nx.len;
				hdr_q   <= snap_nx.hdr;
				ext_q   <= snap_nx.ext_words;
				prev_q  <= s_tdata;
				ovf_q   <= snap_nx.overflow;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			snap_s1 <= snap_nx;
			last_s1 <= s_tlast;
		end
	end

	rhp_result u_result (
		.snap          (snap_s1),
		.strip_padding (strip_q),
		.res           (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_to_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_to_out) begin
			res_q <= res_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, res_q};

endmodule

`default_nettype wire

### hdl/rhp_checker.sv
// Port-level checks for the RTP header parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rhp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [55:0] m_tdata
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A failed check carries no offset, length or padding.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] != 3'd0) |-> (m_tdata[42:3] == 40'd0))
		else $error("failed packet carries payload fields");

	// A good packet's payload never starts inside the fixed header.
	a_ok_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == 3'd0) |-> (m_tdata[18:3] >= 16'd12))
		else $error("payload offset inside fixed header");

	// A fresh result rises only after a final-byte transfer.
	a_rise_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("result without a final byte");

endmodule

bind rtp_header_parser rhp_checker u_rhp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
